// File: hdl/neighbour_sum_prune_filter_assert.svh
// assertion macros for the neighbour-sum prune filter
`ifndef NEIGHBOUR_SUM_PRUNE_FILTER_ASSERT_SVH
`define NEIGHBOUR_SUM_PRUNE_FILTER_ASSERT_SVH

// checked on every rising edge while out of reset
`define NPF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define NPF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/npf_pkg.sv
`default_nettype none
package npf_pkg;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned THR_W      = 4;
  localparam int unsigned OROW_W     = 12;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_NEIGHBOURS = 2'd2;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 13'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
  localparam logic [THR_W-1:0] RST_MIN_NEIGHBOURS = 4'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lb_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/npf_ram.sv
`default_nettype none
module npf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/npf_line_buf.sv
`default_nettype none
module npf_line_buf #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire npf_pkg::lb_ctrl_t            ctrl_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  wire logic [npf_pkg::PIX_W-1:0]    wr_px_i,
  output logic      [npf_pkg::PIX_W-1:0]    up_o,
  output logic      [npf_pkg::PIX_W-1:0]    mid_o
);

  logic [npf_pkg::PIX_W-1:0] up_rd;
  logic [npf_pkg::PIX_W-1:0] mid_rd;
  logic                      fwd_q;
  logic [npf_pkg::PIX_W-1:0] fwd_up_q;
  logic [npf_pkg::PIX_W-1:0] fwd_mid_q;

  npf_ram #(
    .WIDTH (npf_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (mid_o),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (up_rd)
  );

  npf_ram #(
    .WIDTH (npf_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_px_i),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (mid_rd)
  );

  // read of the column being written in the same cycle takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      fwd_q <= ctrl_i.wr_en && (rd_addr_i == wr_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      fwd_up_q  <= mid_o;
      fwd_mid_q <= wr_px_i;
    end
  end

  assign up_o  = fwd_q ? fwd_up_q : up_rd;
  assign mid_o = fwd_q ? fwd_mid_q : mid_rd;

endmodule
`default_nettype wire

// File: hdl/npf_window.sv
`default_nettype none
module npf_window (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      shift_i,
  input  wire logic [npf_pkg::PIX_W-1:0] up_i,
  input  wire logic [npf_pkg::PIX_W-1:0] mid_i,
  input  wire logic [npf_pkg::PIX_W-1:0] px_i,
  input  wire logic                      border_i,
  input  wire logic [npf_pkg::THR_W-1:0] min_neighbours_i,
  output logic      [npf_pkg::PIX_W-1:0] value_o
);

  localparam int unsigned SUM_W = npf_pkg::PIX_W + 4;

  // left and centre columns per row; the right column is the live input
  logic [npf_pkg::PIX_W-1:0] win_q [3][2];
  logic [npf_pkg::PIX_W-1:0] centre;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          thresh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
      end
      win_q[0][1] <= up_i;
      win_q[1][1] <= mid_i;
      win_q[2][1] <= px_i;
    end
  end

  assign centre = win_q[1][1];

  assign sum = SUM_W'(win_q[0][0]) + SUM_W'(win_q[0][1]) + SUM_W'(up_i)
             + SUM_W'(win_q[1][0]) + SUM_W'(mid_i)
             + SUM_W'(win_q[2][0]) + SUM_W'(win_q[2][1]) + SUM_W'(px_i);

  // threshold times 255
  assign thresh = {min_neighbours_i, {npf_pkg::PIX_W{1'b0}}} - SUM_W'(min_neighbours_i);

  always_comb begin
    if (border_i || (sum >= thresh)) begin
      value_o = centre;
    end else begin
      value_o = '0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/neighbour_sum_prune_filter.sv
// Neighbour-sum prune filter over a raster-order 8-bit grey stream.
// Input channel: in_valid_i/in_ready_o with kind_i (pixel or flush) and pixel_in_i.
// Output channel: out_valid_o/out_ready_i with pixel_out_o and frame_last_o.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 image width, 1 image height, 2 min neighbours); write only while idle.
// A frame is W*H pixel requests followed by W+1 flush requests; the first W+1
// requests of a frame give no result, every later one gives exactly one, and
// the result for the final pixel carries frame_last_o.
// Throughput: one request per cycle while the output is not stalled. The two line
// stores are one-port-read memories read in the accept cycle; the window and keep
// decision use the read data while the request sits in the memory stage and then
// load the output register.
// A stalled output holds its result; the input keeps flowing until the memory
// stage also holds a request that produces a result, then in_ready_o drops.
// Reset clears counters, window and configuration to defaults; the line stores
// need no clearing pass, unwritten entries only feed border pixels.
`default_nettype none
module neighbour_sum_prune_filter #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [npf_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [npf_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      kind_i,
  input  wire logic [npf_pkg::PIX_W-1:0] pixel_in_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [npf_pkg::PIX_W-1:0] pixel_out_o,
  output logic                           frame_last_o
);

  `include "neighbour_sum_prune_filter_assert.svh"

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW = CW + 1;
  localparam int unsigned HW = npf_pkg::CFG_W;
  localparam int unsigned RW = npf_pkg::OROW_W;

  // configuration
  logic [npf_pkg::CFG_W-1:0] width_q;
  logic [npf_pkg::CFG_W-1:0] height_q;
  logic [npf_pkg::THR_W-1:0] min_nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= npf_pkg::RST_IMAGE_WIDTH;
      height_q <= npf_pkg::RST_IMAGE_HEIGHT;
      min_nb_q <= npf_pkg::RST_MIN_NEIGHBOURS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        npf_pkg::REG_IMAGE_WIDTH:    width_q  <= cfg_wdata_i;
        npf_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_wdata_i;
        npf_pkg::REG_MIN_NEIGHBOURS: min_nb_q <= cfg_wdata_i[npf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [XW-1:0] w_x;
  logic [XW-1:0] wm1_x;
  logic [HW-1:0] hm1;

  always_comb begin
    if (32'(width_q) < 32'd3) begin
      w_eff = WW'(3);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (32'(height_q) < 32'd3) begin
      h_eff = HW'(3);
    end else if (32'(height_q) > 32'(npf_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(npf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign w_x   = XW'(w_eff);
  assign wm1_x = w_x - XW'(1);
  assign hm1   = h_eff - HW'(1);

  // handshake
  logic          s1_valid_q;
  logic          s1_emit_q;
  logic [CW-1:0] s1_col_q;
  logic [npf_pkg::PIX_W-1:0] s1_px_q;
  logic          out_valid_q;
  logic [npf_pkg::PIX_W-1:0] out_px_q;
  logic          out_last_q;
  logic          in_fire;
  logic          out_free;
  logic          s1_fire;
  logic          s1_out;
  logic          last_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!s1_emit_q || out_free);
  assign s1_out     = s1_fire && s1_emit_q;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // output position
  logic [CW-1:0] oc_q;
  logic [RW-1:0] orow_q;
  logic [CW-1:0] oc_eff;
  logic          orow_ge;
  logic          oc_ge;
  logic          border;
  logic          last;

  always_comb begin
    if (XW'(oc_q) >= w_x) begin
      oc_eff = CW'(wm1_x);
    end else begin
      oc_eff = oc_q;
    end
  end

  assign orow_ge = HW'(orow_q) >= hm1;
  assign oc_ge   = XW'(oc_eff) >= wm1_x;
  assign border  = (orow_q == '0) || orow_ge || (oc_eff == '0) || oc_ge;
  assign last    = orow_ge && oc_ge;
  assign last_fire = s1_out && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q   <= '0;
      orow_q <= '0;
    end else if (s1_out) begin
      if (last) begin
        oc_q   <= '0;
        orow_q <= '0;
      end else if ((XW'(oc_eff) + XW'(1)) >= w_x) begin
        oc_q   <= '0;
        orow_q <= orow_q + RW'(1);
      end else begin
        oc_q <= oc_eff + CW'(1);
      end
    end
  end

  // input position, restarted by the frame's final result
  logic [CW-1:0] in_col_q;
  logic [HW-1:0] in_row_q;
  logic [CW-1:0] cur_col;
  logic [HW-1:0] cur_row;
  logic          cur_emit;
  logic          col_wrap;

  assign cur_col  = last_fire ? '0 : in_col_q;
  assign cur_row  = last_fire ? '0 : in_row_q;
  assign cur_emit = (cur_row >= HW'(2)) || ((cur_row == HW'(1)) && (cur_col != '0));
  assign col_wrap = (XW'(cur_col) + XW'(1)) >= w_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        in_col_q <= '0;
        in_row_q <= cur_row + HW'(1);
      end else begin
        in_col_q <= cur_col + CW'(1);
        in_row_q <= cur_row;
      end
    end else if (last_fire) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end
  end

  // memory read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      s1_emit_q  <= cur_emit;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q <= cur_col;
      s1_px_q  <= (kind_i == npf_pkg::KIND_FLUSH) ? '0 : pixel_in_i;
    end
  end

  npf_pkg::lb_ctrl_t         lb_ctrl;
  logic [npf_pkg::PIX_W-1:0] up_px;
  logic [npf_pkg::PIX_W-1:0] mid_px;
  logic [npf_pkg::PIX_W-1:0] value;

  assign lb_ctrl.rd_en = in_fire;
  assign lb_ctrl.wr_en = s1_fire;

  npf_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lb_ctrl),
    .rd_addr_i (cur_col),
    .wr_addr_i (s1_col_q),
    .wr_px_i   (s1_px_q),
    .up_o      (up_px),
    .mid_o     (mid_px)
  );

  npf_window u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .shift_i          (s1_fire),
    .up_i             (up_px),
    .mid_i            (mid_px),
    .px_i             (s1_px_q),
    .border_i         (border),
    .min_neighbours_i (min_nb_q),
    .value_o          (value)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_out) begin
      out_px_q   <= value;
      out_last_q <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = out_px_q;
  assign frame_last_o = out_last_q;

  `NPF_ASSERT(a_ready_when_empty, !s1_valid_q |-> in_ready_o, "input stalled with empty stage")
  `NPF_ASSERT(a_accept_fills_stage, in_fire |=> s1_valid_q, "accepted request lost")
  `NPF_ASSERT(a_last_restarts, last_fire |=> (oc_q == '0) && (orow_q == '0), "frame end did not restart")
  `NPF_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_W         = npf_pkg::IDX_W;
  localparam int unsigned PIX_W         = npf_pkg::PIX_W;
  localparam int unsigned CFG_W         = npf_pkg::CFG_W;
  localparam int unsigned THR_W         = npf_pkg::THR_W;
  localparam int unsigned LINE_DEPTH    = 4096;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned FULL_BYTE     = 255;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pix_value;
    logic             frame_last;
  } filt_result_t;

  typedef enum int unsigned {
    TEX_UNIFORM,
    TEX_BINARY,
    TEX_SPARSE
  } texture_e;

  class prune_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [THR_W-1:0] keep_thr;
    logic [PIX_W-1:0] upper_line [LINE_DEPTH];
    logic [PIX_W-1:0] middle_line [LINE_DEPTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_col;
    int unsigned out_row;
    filt_result_t expected_q [$];
    int unsigned errors;

    function new();
      width_reg = npf_pkg::RST_IMAGE_WIDTH;
      height_reg = npf_pkg::RST_IMAGE_HEIGHT;
      keep_thr = npf_pkg::RST_MIN_NEIGHBOURS;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        npf_pkg::REG_IMAGE_WIDTH: width_reg = data;
        npf_pkg::REG_IMAGE_HEIGHT: height_reg = data;
        npf_pkg::REG_MIN_NEIGHBOURS: keep_thr = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned frame_width();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned frame_height();
      if (height_reg < 3) return 3;
      if (height_reg > npf_pkg::MAX_HEIGHT) return npf_pkg::MAX_HEIGHT;
      return height_reg;
    endfunction

    function bit at_frame_start();
      return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // advance the window by one request and queue the pixel it completes, if any
    function void note_request(logic kind, logic [PIX_W-1:0] pix_in);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned oc;
      int unsigned orow;
      int unsigned sum;
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] pre_centre;
      bit emit;
      filt_result_t res;
      w = frame_width();
      h = frame_height();
      px = (kind == npf_pkg::KIND_FLUSH) ? '0 : pix_in;
      col = in_col;
      up = '0;
      mid = '0;
      pre_centre = win[1][2];
      if (col < LINE_DEPTH) begin
        up = upper_line[col];
        mid = middle_line[col];
        upper_line[col] = mid;
        middle_line[col] = px;
      end
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      emit = (in_row >= 2) || (in_row == 1 && col >= 1);
      if (col + 1 >= w) begin
        in_col = 0;
        in_row = (in_row + 1) & 32'h1FFF;
      end else begin
        in_col = col + 1;
      end
      if (!emit) return;
      oc = out_col;
      orow = out_row;
      if (oc >= w) oc = w - 1;
      if (orow == 0 || orow >= h - 1 || oc == 0 || oc >= w - 1) begin
        res.pix_value = (oc >= w - 1) ? pre_centre : win[1][1];
      end else begin
        sum = win[0][0] + win[0][1] + win[0][2] + win[1][0] + win[1][2]
            + win[2][0] + win[2][1] + win[2][2];
        res.pix_value = (sum >= keep_thr * FULL_BYTE) ? win[1][1] : '0;
      end
      res.frame_last = (orow >= h - 1) && (oc >= w - 1);
      expected_q.push_back(res);
      if (res.frame_last) begin
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
      end else if (oc + 1 >= w) begin
        out_col = 0;
        out_row = (orow + 1) & 32'hFFF;
      end else begin
        out_col = oc + 1;
      end
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic [PIX_W-1:0] got_value, logic got_last);
      filt_result_t exp_r;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result pixel_out=%0d frame_last=%0b",
                             got_value, got_last));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got_value !== exp_r.pix_value)
        flag_error($sformatf("pixel_out expected %0d got %0d", exp_r.pix_value, got_value));
      if (got_last !== exp_r.frame_last)
        flag_error($sformatf("frame_last expected %0b got %0b", exp_r.frame_last, got_last));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             kind_i = npf_pkg::KIND_PIXEL;
  logic [PIX_W-1:0] pixel_in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [PIX_W-1:0] pixel_out_o;
  logic             frame_last_o;

  prune_scoreboard sb = new();
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 58;
  int unsigned accepted_items = 0;
  int unsigned idle_cycles = 0;

  neighbour_sum_prune_filter #(
    .MAX_WIDTH(LINE_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .frame_last_o(frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(pixel_out_o, frame_last_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [PIX_W-1:0] gen_pixel(texture_e tex);
    case (tex)
      TEX_BINARY: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      TEX_SPARSE: return ($urandom_range(9) == 0) ? PIX_W'($urandom) : 8'h00;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic k, input logic [PIX_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    pixel_in_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(k, p);
    accepted_items++;
  endtask

  task automatic send_run(input int unsigned n, input logic main_kind, input texture_e tex,
                          input int unsigned flip_pct);
    logic k;
    for (int unsigned i = 0; i < n; i++) begin
      k = ($urandom_range(99) < flip_pct) ? ~main_kind : main_kind;
      send_item(k, gen_pixel(tex));
    end
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] thr);
    logic [IDX_W-1:0] idx [4];
    logic [CFG_W-1:0] data [4];
    idx = '{npf_pkg::REG_IMAGE_WIDTH, npf_pkg::REG_IMAGE_HEIGHT,
            npf_pkg::REG_MIN_NEIGHBOURS, REG_SPARE};
    data = '{w, h, thr, CFG_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= data[i];
      sb.write_reg(idx[i], data[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] thr;
    w = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 9));
    h = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 5));
    thr = CFG_W'($urandom);
    thr[THR_W-1:0] = ($urandom_range(99) < 85) ? THR_W'($urandom_range(8))
                                                : THR_W'($urandom_range(9, 15));
    write_config(w, h, thr);
  endtask

  task automatic resync_frame(input texture_e tex);
    for (int n = 0; n < 20000 && !sb.at_frame_start(); n++) begin
      send_item(logic'($urandom_range(1)), gen_pixel(tex));
    end
  endtask

  initial begin : stimulus
    int unsigned random_base;
    int unsigned bulk_items;
    int unsigned progress;
    int unsigned w;
    int unsigned h;
    int unsigned n_flush;
    int unsigned cut;
    int unsigned shape;
    int unsigned start_count;
    texture_e tex;
    bit big_height_done;
    bulk_items = 0;
    big_height_done = 0;
    rst_ni <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clamped sizes, all-white neighbourhood exactly at the top threshold
    write_config(13'd0, 13'd1, 13'd8);
    for (int i = 0; i < 9; i++) send_item(npf_pkg::KIND_PIXEL, (i == 4) ? 8'hA5 : 8'hFF);
    for (int i = 0; i < 4; i++) send_item(npf_pkg::KIND_FLUSH, 8'hC3);
    pause_until_drained();

    // threshold above eight, flush inside the frame, pixel in the flush phase
    write_config(13'd3, 13'd3, 13'h1FFF);
    for (int i = 0; i < 9; i++) begin
      send_item((i == 3) ? npf_pkg::KIND_FLUSH : npf_pkg::KIND_PIXEL,
                (i == 4) ? 8'h5A : 8'hFF);
    end
    for (int i = 0; i < 4; i++) begin
      send_item((i == 2) ? npf_pkg::KIND_PIXEL : npf_pkg::KIND_FLUSH, 8'h7E);
    end
    pause_until_drained();

    // widest random line first, so both line stores hold data in every column used later
    random_base = accepted_items;
    start_count = accepted_items;
    write_config(13'd9, 13'd3, CFG_W'($urandom_range(8)));
    w = sb.frame_width();
    send_run(w * 3, npf_pkg::KIND_PIXEL, TEX_BINARY, 1);
    send_run(w + 1, npf_pkg::KIND_FLUSH, TEX_BINARY, 1);
    pause_until_drained();
    bulk_items += accepted_items - start_count;

    progress = 0;
    while (progress < RANDOM_ITEMS) begin
      if (progress < RANDOM_ITEMS / 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 58;
      end else if (progress < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      tex = texture_e'($urandom_range(2));
      if (!big_height_done && progress >= 400) begin
        // tallest frame, cut short by a size change
        big_height_done = 1;
        write_config(13'd3, 13'h1FFF, CFG_W'($urandom_range(8)));
        send_run(30, npf_pkg::KIND_PIXEL, tex, 1);
        pause_until_drained();
        random_config();
        resync_frame(tex);
        pause_until_drained();
      end else begin
        random_config();
        w = sb.frame_width();
        h = sb.frame_height();
        shape = $urandom_range(99);
        if (shape < 80) begin
          cut = $urandom_range(1, w * h);
          send_run(cut, npf_pkg::KIND_PIXEL, tex, 3);
          if ($urandom_range(9) == 0) pause_until_drained();
          send_run(w * h - cut, npf_pkg::KIND_PIXEL, tex, 3);
          send_run(w + 1, npf_pkg::KIND_FLUSH, tex, 3);
        end else if (shape < 90) begin
          n_flush = ($urandom_range(1) != 0) ? w + 1 - $urandom_range(1, w)
                                             : w + 1 + $urandom_range(1, w);
          send_run(w * h, npf_pkg::KIND_PIXEL, tex, 3);
          send_run(n_flush, npf_pkg::KIND_FLUSH, tex, 3);
        end else begin
          // size and threshold change in the middle of a frame
          send_run($urandom_range(1, w * h), npf_pkg::KIND_PIXEL, tex, 3);
          pause_until_drained();
          random_config();
        end
        resync_frame(tex);
        pause_until_drained();
      end
      progress = accepted_items - random_base - bulk_items;
    end

    pause_until_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
